>>> rtl/rotor_cipher_encode_core_assert.svh
// Assertion macros used by the rotor cipher sequencer, rce_ctrl.
// Users must have clk and rst_n in scope where a macro is expanded.
`ifndef ROTOR_CIPHER_ENCODE_CORE_ASSERT_SVH
`define ROTOR_CIPHER_ENCODE_CORE_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define RCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define RCE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rce_pkg.sv
// Package of the rotor cipher: item field types, operation codes and fixed constants.
// Depends on nothing; rce_ctrl and rotor_cipher_encode_core import it.
package rce_pkg;

    localparam int OP_W    = 2;
    localparam int SEL_W   = 3;
    localparam int FIELD_W = 5;
    localparam int CNT_W   = 4;

    localparam logic [OP_W-1:0] OP_ENCODE   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_ROT = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_REF = 2'd2;
    localparam logic [OP_W-1:0] OP_SET_POS  = 2'd3;

    localparam logic [CNT_W-1:0] ROTORS_RESET = 4'd3;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [SEL_W-1:0]   sel_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef struct packed {
        op_t    op;
        sel_t   rotor_select;
        field_t table_index;
        field_t table_value;
    } cmd_item_t;

    typedef struct packed {
        field_t cipher_symbol;
    } result_item_t;

    typedef struct packed {
        cnt_t rotors_in_use;
    } cfg_item_t;

endpackage

>>> rtl/rce_chan_if.sv
// Valid/ready channel interface used for the command, result and configuration ports.
// The payload type is set per instance, normally to a struct from rce_pkg.
interface rce_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rce_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Holds the wiring and reflector tables; depends on nothing.
module rce_ram #(
    parameter int DEPTH = 26,
    parameter int DW = 5,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/rce_ctrl.sv
// Rotor cipher sequencer: command decode, rotor positions, odometer stepping and the
// hop-by-hop wiring memory walk. Depends on rce_pkg, rce_chan_if, the assertion macros.
`include "rotor_cipher_encode_core_assert.svh"

module rce_ctrl #(
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_ROTORS = 8,
    localparam int SW = $clog2(ALPHABET_SIZE),
    localparam int FAW = $clog2((MAX_ROTORS + 1) * ALPHABET_SIZE),
    localparam int IAW = $clog2(MAX_ROTORS * ALPHABET_SIZE)
) (
    input  logic           clk,
    input  logic           rst_n,
    rce_chan_if.sink       cmd,
    rce_chan_if.source     result,
    rce_chan_if.sink       cfg,
    output logic           fwd_we,
    output logic [FAW-1:0] fwd_waddr,
    output logic [SW-1:0]  fwd_wdata,
    output logic [FAW-1:0] fwd_raddr,
    input  logic [SW-1:0]  fwd_rdata,
    output logic           inv_we,
    output logic [IAW-1:0] inv_waddr,
    output logic [SW-1:0]  inv_wdata,
    output logic [IAW-1:0] inv_raddr,
    input  logic [SW-1:0]  inv_rdata
);
    import rce_pkg::*;

    localparam int RW = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
    localparam int RED_N = 2 ** FIELD_W;
    localparam logic signed [SW+2:0] A_S = (SW + 3)'(ALPHABET_SIZE);
    localparam logic [FAW-1:0] A_F = FAW'(ALPHABET_SIZE);
    localparam logic [FAW-1:0] REFL_BASE = FAW'(MAX_ROTORS * ALPHABET_SIZE);
    localparam logic [SW-1:0] SYM_LAST = SW'(ALPHABET_SIZE - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADV  = 3'd1;
    localparam logic [2:0] S_FWD0 = 3'd2;
    localparam logic [2:0] S_FWD  = 3'd3;
    localparam logic [2:0] S_REF  = 3'd4;
    localparam logic [2:0] S_INV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [SW-1:0]  pos_reg [MAX_ROTORS];
    cnt_t           rot_cnt_reg;
    logic [SW-1:0]  sym_reg, sym_next;
    logic [RW-1:0]  i_reg, i_next;
    logic [RW-1:0]  last_reg, last_next;
    logic [FAW-1:0] base_reg, base_next;
    logic [SW-1:0]  prev_reg, prev_next;
    logic [SW-1:0]  res_reg, res_next;
    logic           out_valid_reg, out_valid_next;
    field_t         out_data_reg, out_data_next;

    logic [SW-1:0]  red_lut [RED_N];
    logic           cmd_acc;
    logic           sel_ok, idx_ok;
    logic [SW-1:0]  val_red;
    logic           pos_we;
    logic [RW-1:0]  pos_wi;
    logic [SW-1:0]  pos_wd;
    logic [SW-1:0]  hop_sym;
    logic [FAW-1:0] inv_full;

    // Returns (a + b - c) modulo the alphabet size; all operands lie below it.
    function automatic logic [SW-1:0] wrap3(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                            input logic [SW-1:0] c);
        logic signed [SW+2:0] s;
        s = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
        if (s[SW+2])
        begin
            s = s + A_S;
        end
        else if (s >= A_S)
        begin
            s = s - A_S;
        end
        return s[SW-1:0];
    endfunction

    for (genvar k = 0; k < RED_N; k++)
    begin : g_red
        assign red_lut[k] = SW'(k % ALPHABET_SIZE);
    end

    assign cmd_acc = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign sel_ok = (32'(cmd.data.rotor_select) < MAX_ROTORS);
    assign idx_ok = (32'(cmd.data.table_index) < ALPHABET_SIZE);
    assign val_red = red_lut[cmd.data.table_value];

    assign fwd_we = cmd_acc && (((cmd.data.op == OP_LOAD_ROT) && sel_ok && idx_ok) ||
                                ((cmd.data.op == OP_LOAD_REF) && idx_ok));
    assign fwd_waddr = (cmd.data.op == OP_LOAD_REF) ?
                       REFL_BASE + FAW'(cmd.data.table_index) :
                       FAW'(int'(cmd.data.rotor_select) * ALPHABET_SIZE +
                            int'(cmd.data.table_index));
    assign fwd_wdata = val_red;
    assign inv_we = cmd_acc && (cmd.data.op == OP_LOAD_ROT) && sel_ok && idx_ok;
    assign inv_waddr = IAW'(int'(cmd.data.rotor_select) * ALPHABET_SIZE + int'(val_red));
    assign inv_wdata = SW'(cmd.data.table_index);

    assign result.valid = out_valid_reg;
    assign result.data.cipher_symbol = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        sym_next = sym_reg;
        i_next = i_reg;
        last_next = last_reg;
        base_next = base_reg;
        prev_next = prev_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next = out_data_reg;
        pos_we = 1'b0;
        pos_wi = RW'(cmd.data.rotor_select);
        pos_wd = val_red;
        fwd_raddr = '0;
        inv_full = '0;
        hop_sym = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.data.op)
                        OP_ENCODE:
                        begin
                            sym_next = red_lut[cmd.data.table_index];
                            i_next = '0;
                            base_next = '0;
                            if (rot_cnt_reg == '0)
                            begin
                                last_next = '0;
                            end
                            else if (32'(rot_cnt_reg) > MAX_ROTORS)
                            begin
                                last_next = RW'(MAX_ROTORS - 1);
                            end
                            else
                            begin
                                last_next = RW'(32'(rot_cnt_reg) - 1);
                            end
                            state_next = S_ADV;
                        end
                        OP_SET_POS:
                        begin
                            pos_we = sel_ok;
                        end
                        default:
                        begin
                            pos_we = 1'b0;
                        end
                    endcase
                end
            end
            S_ADV:
            begin
                pos_we = 1'b1;
                pos_wi = i_reg;
                if (pos_reg[i_reg] >= SYM_LAST)
                begin
                    pos_wd = '0;
                    if (i_reg == last_reg)
                    begin
                        i_next = '0;
                        state_next = S_FWD0;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    pos_wd = pos_reg[i_reg] + 1'b1;
                    i_next = '0;
                    state_next = S_FWD0;
                end
            end
            S_FWD0:
            begin
                hop_sym = wrap3(sym_reg, pos_reg[0], '0);
                fwd_raddr = FAW'(hop_sym);
                prev_next = pos_reg[0];
                state_next = S_FWD;
            end
            S_FWD:
            begin
                if (i_reg == last_reg)
                begin
                    hop_sym = wrap3(fwd_rdata, '0, prev_reg);
                    fwd_raddr = REFL_BASE + FAW'(hop_sym);
                    state_next = S_REF;
                end
                else
                begin
                    hop_sym = wrap3(fwd_rdata, pos_reg[i_reg + 1'b1], prev_reg);
                    fwd_raddr = base_reg + A_F + FAW'(hop_sym);
                    base_next = base_reg + A_F;
                    prev_next = pos_reg[i_reg + 1'b1];
                    i_next = i_reg + 1'b1;
                end
            end
            S_REF:
            begin
                hop_sym = wrap3(fwd_rdata, prev_reg, '0);
                inv_full = base_reg + FAW'(hop_sym);
                state_next = S_INV;
            end
            S_INV:
            begin
                if (i_reg == '0)
                begin
                    res_next = wrap3(inv_rdata, '0, prev_reg);
                    state_next = S_OUT;
                end
                else
                begin
                    hop_sym = wrap3(inv_rdata, pos_reg[i_reg - 1'b1], prev_reg);
                    inv_full = base_reg - A_F + FAW'(hop_sym);
                    base_next = base_reg - A_F;
                    prev_next = pos_reg[i_reg - 1'b1];
                    i_next = i_reg - 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = FIELD_W'(res_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign inv_raddr = inv_full[IAW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            rot_cnt_reg <= ROTORS_RESET;
            for (int k = 0; k < MAX_ROTORS; k++)
            begin
                pos_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                rot_cnt_reg <= cfg.data.rotors_in_use;
            end
            if (pos_we)
            begin
                pos_reg[pos_wi] <= pos_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        i_reg <= i_next;
        last_reg <= last_next;
        base_reg <= base_next;
        prev_reg <= prev_next;
        res_reg <= res_next;
        out_data_reg <= out_data_next;
    end

    `RCE_ASSERT(a_hop_in_range, (state_reg == S_FWD || state_reg == S_INV) |-> (i_reg <= last_reg), "rotor hop index beyond rotors in use")
    `RCE_ASSERT(a_fwd_base, (state_reg == S_FWD || state_reg == S_INV) |-> (base_reg == FAW'(int'(i_reg) * ALPHABET_SIZE)), "wiring row base does not match rotor index")
    `RCE_ASSERT(a_inv_done, (state_reg == S_INV && i_reg == '0) |=> (state_reg == S_OUT), "last inverse hop did not finish the item")
    `RCE_ASSERT(a_result_src, $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT), "result raised outside the output step")
endmodule

>>> rtl/rotor_cipher_encode_core.sv
// Top level of the rotor cipher encoder: sequencer plus the forward and inverse table RAMs.
// Depends on rce_pkg, rce_chan_if, rce_ram and rce_ctrl.
//
// Usage: commands arrive on cmd (valid/ready). Op encode returns one item on result;
// ops load rotor wiring, load reflector entry and set position return nothing and
// complete in the cycle they are accepted. cfg writes rotors_in_use and is always ready;
// write it only while no encode is in flight.
// An encode item is accepted, then the odometer steps: rotors in use wrap to zero in
// turn and carry on, until one advances without wrapping or the last one has stepped.
// Then comes one table read per hop: forward hops through the rotors in use, one
// reflector hop and the inverse hops back, the last one taking off the entry offset,
// and then the output register is loaded. Each table RAM has a single read port.
// One item is worked on at a time; cmd is ready only while the sequencer is idle.
// Reset clears the positions to zero and sets rotors_in_use to 3; table contents are
// undefined until loaded. When the receiver stalls, the result waits in the output
// register and the block still accepts the next command; a following encode holds
// in its output step until the earlier item is taken.
module rotor_cipher_encode_core #(
    parameter int ALPHABET_SIZE = 26,
    parameter int MAX_ROTORS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    rce_chan_if.sink   cmd,
    rce_chan_if.source result,
    rce_chan_if.sink   cfg
);
    import rce_pkg::*;

    localparam int SW = $clog2(ALPHABET_SIZE);
    localparam int FWD_DEPTH = (MAX_ROTORS + 1) * ALPHABET_SIZE;
    localparam int INV_DEPTH = MAX_ROTORS * ALPHABET_SIZE;
    localparam int FAW = $clog2(FWD_DEPTH);
    localparam int IAW = $clog2(INV_DEPTH);

    logic           fwd_we;
    logic [FAW-1:0] fwd_waddr;
    logic [SW-1:0]  fwd_wdata;
    logic [FAW-1:0] fwd_raddr;
    logic [SW-1:0]  fwd_rdata;
    logic           inv_we;
    logic [IAW-1:0] inv_waddr;
    logic [SW-1:0]  inv_wdata;
    logic [IAW-1:0] inv_raddr;
    logic [SW-1:0]  inv_rdata;

    rce_ctrl #(
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .MAX_ROTORS(MAX_ROTORS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .result(result),
        .cfg(cfg),
        .fwd_we(fwd_we),
        .fwd_waddr(fwd_waddr),
        .fwd_wdata(fwd_wdata),
        .fwd_raddr(fwd_raddr),
        .fwd_rdata(fwd_rdata),
        .inv_we(inv_we),
        .inv_waddr(inv_waddr),
        .inv_wdata(inv_wdata),
        .inv_raddr(inv_raddr),
        .inv_rdata(inv_rdata)
    );

    rce_ram #(
        .DEPTH(FWD_DEPTH),
        .DW(SW)
    ) u_fwd_ram (
        .clk(clk),
        .we(fwd_we),
        .waddr(fwd_waddr),
        .wdata(fwd_wdata),
        .raddr(fwd_raddr),
        .rdata(fwd_rdata)
    );

    rce_ram #(
        .DEPTH(INV_DEPTH),
        .DW(SW)
    ) u_inv_ram (
        .clk(clk),
        .we(inv_we),
        .waddr(inv_waddr),
        .wdata(inv_wdata),
        .raddr(inv_raddr),
        .rdata(inv_rdata)
    );
endmodule
